>>> src/sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH_DEF        = 10;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int PRIO_W = 3;
  localparam int WORD_W = 32;
  localparam int OCC_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
  } spq_cmd_t;

endpackage

>>> src/spq_cell.sv
module spq_cell #(
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_pkg::spq_cmd_t         cmd,
  input  logic [PAYLOAD_BITS-1:0]   new_payload,
  // neighbor toward the head
  input  logic [spq_pkg::PRIO_W-1:0] up_prio,
  input  logic [PAYLOAD_BITS-1:0]   up_payload,
  input  logic                      up_keep,
  // neighbor toward the tail
  input  logic [spq_pkg::PRIO_W-1:0] dn_prio,
  input  logic [PAYLOAD_BITS-1:0]   dn_payload,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [PAYLOAD_BITS-1:0]   payload,
  output logic                      keep
);
  import spq_pkg::*;

  logic [PRIO_W-1:0]       prio_r, prio_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;

  // an empty cell holds priority 0, so it never keeps against a legal insert
  assign keep = prio_r >= cmd.prio;

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (cmd.enq && !keep) begin
      if (up_keep) begin
        prio_nxt    = cmd.prio;
        payload_nxt = new_payload;
      end else begin
        prio_nxt    = up_prio;
        payload_nxt = up_payload;
      end
    end else if (cmd.deq) begin
      prio_nxt    = dn_prio;
      payload_nxt = dn_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
    end else begin
      prio_r <= prio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

>>> src/sorted_priority_queue.sv
// sorted priority queue: holds up to DEPTH entries of a priority (1 lowest,
// 5 highest) and a payload word, kept in descending priority order with
// equal priorities leaving in arrival order. an input word with op enqueue
// inserts behind every entry of equal or higher priority (priority 0 is
// taken as 1, 6 and 7 as 5); op dequeue removes the head. every input word
// yields exactly one output word with a status (done, full, empty), the
// dequeued priority and payload (zero otherwise) and the occupancy after the
// operation, cut to four bits. the store is a chain of DEPTH cells that all
// compare against the incoming priority and shift toward their neighbor in
// the same cycle, so one word is taken every cycle, with its result captured
// in an output register; the input is stalled only while that register
// holds a word the receiver is stalling. reset empties the queue at once,
// there is no clearing sweep.
module sorted_priority_queue #(
  parameter int DEPTH        = spq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [spq_pkg::PRIO_W-1:0]   in_new_priority,
  input  logic [spq_pkg::WORD_W-1:0]   in_new_payload,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spq_pkg::STAT_W-1:0]   out_status,
  output logic [spq_pkg::PRIO_W-1:0]   out_head_priority,
  output logic [spq_pkg::WORD_W-1:0]   out_head_payload,
  output logic [spq_pkg::OCC_W-1:0]    out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // occupancy counter
  logic [CNT_W-1:0] count_r, count_nxt;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [PRIO_W-1:0] head_prio_r, head_prio_nxt;
  logic [WORD_W-1:0] head_pay_r, head_pay_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [PRIO_W-1:0] prio_clamped;
  spq_cmd_t          cmd;

  // width adapters between the port word and the stored payload
  logic [PAYLOAD_BITS+WORD_W-1:0] in_pay_wide;
  logic [PAYLOAD_BITS-1:0]        in_pay;
  logic [PAYLOAD_BITS+WORD_W-1:0] head_pay_wide;
  logic [CNT_W+OCC_W-1:0]         count_wide;

  // chain taps
  logic [PRIO_W-1:0]       cell_prio [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay  [DEPTH];
  logic                    cell_keep [DEPTH];

  // a new word can enter whenever the output register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full  = count_r == CNT_FULL;
  assign is_empty = count_r == '0;

  // out-of-range priorities are pulled into 1..5
  always_comb begin
    if (in_new_priority < PRIO_MIN) begin
      prio_clamped = PRIO_MIN;
    end else if (in_new_priority > PRIO_MAX) begin
      prio_clamped = PRIO_MAX;
    end else begin
      prio_clamped = in_new_priority;
    end
  end

  assign in_pay_wide = {{PAYLOAD_BITS{1'b0}}, in_new_payload};
  assign in_pay      = in_pay_wide[PAYLOAD_BITS-1:0];

  // only operations that succeed move the chain
  assign cmd.enq  = accept && (in_op == OP_ENQ) && !is_full;
  assign cmd.deq  = accept && (in_op == OP_DEQ) && !is_empty;
  assign cmd.prio = prio_clamped;

  // the chain: cell 0 is the head, the last cell pulls in an empty slot
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PRIO_W-1:0]       up_prio, dn_prio;
    logic [PAYLOAD_BITS-1:0] up_pay, dn_pay;
    logic                    up_keep;

    if (i == 0) begin : g_head
      // nothing ahead of the head: an insert that reaches it lands here
      assign up_prio = '0;
      assign up_pay  = '0;
      assign up_keep = 1'b1;
    end else begin : g_mid
      assign up_prio = cell_prio[i-1];
      assign up_pay  = cell_pay[i-1];
      assign up_keep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_prio = '0;
      assign dn_pay  = '0;
    end else begin : g_body
      assign dn_prio = cell_prio[i+1];
      assign dn_pay  = cell_pay[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_payload (in_pay),
      .up_prio     (up_prio),
      .up_payload  (up_pay),
      .up_keep     (up_keep),
      .dn_prio     (dn_prio),
      .dn_payload  (dn_pay),
      .prio        (cell_prio[i]),
      .payload     (cell_pay[i]),
      .keep        (cell_keep[i])
    );
  end

  // count tracks the chain
  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign head_pay_wide = {{WORD_W{1'b0}}, cell_pay[0]};
  assign count_wide    = {{OCC_W{1'b0}}, count_nxt};

  // result word: status and head from the state before the chain moves, occupancy after it
  always_comb begin
    head_prio_nxt = '0;
    head_pay_nxt  = '0;
    occ_nxt       = count_wide[OCC_W-1:0];
    if (in_op == OP_ENQ) begin
      status_nxt = is_full ? ST_FULL : ST_DONE;
    end else if (is_empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt    = ST_DONE;
      head_prio_nxt = cell_prio[0];
      head_pay_nxt  = head_pay_wide[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the output register needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      head_prio_r <= head_prio_nxt;
      head_pay_r  <= head_pay_nxt;
      occ_r       <= occ_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_priority = head_prio_r;
  assign out_head_payload  = head_pay_r;
  assign out_occupancy     = occ_r;

endmodule

>>> src/spq_checker.sv
`include "sorted_priority_queue_assert.svh"

module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [spq_pkg::STAT_W-1:0] out_status,
  input logic [spq_pkg::PRIO_W-1:0] out_head_priority,
  input logic [spq_pkg::WORD_W-1:0] out_head_payload,
  input logic [spq_pkg::OCC_W-1:0]  out_occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  // a rejected operation carries no head entry
  `SPQ_ASSERT_NOW(a_reject_no_head, clk, rst_n, out_valid && (out_status != ST_DONE), (out_head_priority == '0) && (out_head_payload == '0), "rejected word carries a head entry")

  // full rejection only at capacity, empty rejection only at zero
  `SPQ_ASSERT_NOW(a_full_occ, clk, rst_n, out_valid && (out_status == ST_FULL), out_occupancy == OCC_FULL, "full status below capacity")
  `SPQ_ASSERT_NOW(a_empty_occ, clk, rst_n, out_valid && (out_status == ST_EMPTY), out_occupancy == '0, "empty status with entries held")

  // a dequeued head always has a legal priority
  `SPQ_ASSERT_NOW(a_head_prio, clk, rst_n, out_valid && (out_head_priority != '0), (out_status == ST_DONE) && (out_head_priority <= PRIO_MAX), "head priority out of range")

  // a stalled word holds
  `SPQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_head_priority) && $stable(out_head_payload) && $stable(out_occupancy), "stalled result word changed")

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_head_priority (out_head_priority),
  .out_head_payload  (out_head_payload),
  .out_occupancy     (out_occupancy)
);

>>> verif/tb_sorted_priority_queue.sv
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int PAYLOAD_BITS   = PAYLOAD_BITS_DEF;
  localparam int RANDOM_WORDS   = 1250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  // payload bits kept by the queue, the rest are dropped on insert
  localparam logic [WORD_W-1:0] KEEP_MASK =
    (PAYLOAD_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << PAYLOAD_BITS) - 1);

  // one output word as the queue should report it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] word;
    logic [OCC_W-1:0]  occ;
  } queue_reply_t;

  // keeps its own sorted copy of the queue and the replies still owed
  class priority_order_tracker;
    logic [PRIO_W-1:0] slot_prio [DEPTH];
    logic [WORD_W-1:0] slot_word [DEPTH];
    int                held;
    queue_reply_t      pending_replies [$];
    int                errors;

    function new();
      foreach (slot_prio[i]) begin
        slot_prio[i] = '0;
        slot_word[i] = '0;
      end
      held   = 0;
      errors = 0;
    endfunction

    // accepted input word: update the copy and queue the reply it earns
    function void note_request(logic op, logic [PRIO_W-1:0] prio, logic [WORD_W-1:0] word);
      queue_reply_t      r;
      logic [PRIO_W-1:0] p;
      int                pos;
      int                i;
      r = '0;
      if (op == OP_ENQ) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // out-of-range priorities are clamped into 1..5
          p = (prio < PRIO_MIN) ? PRIO_MIN : ((prio > PRIO_MAX) ? PRIO_MAX : prio);
          // goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held && slot_prio[pos] >= p) pos++;
          for (i = held; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_word[i] = slot_word[i-1];
          end
          slot_prio[pos] = p;
          slot_word[pos] = word & KEEP_MASK;
          held++;
          r.status = ST_DONE;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.prio = slot_prio[0];
        r.word = slot_word[0];
        for (i = 1; i < DEPTH; i++) begin
          slot_prio[i-1] = slot_prio[i];
          slot_word[i-1] = slot_word[i];
        end
        slot_prio[DEPTH-1] = '0;
        slot_word[DEPTH-1] = '0;
        held--;
        r.status = ST_DONE;
      end
      r.occ = OCC_W'(held);
      pending_replies.push_back(r);
    endfunction

    function void report_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // accepted output word: compare against the oldest reply owed
    function void check_reply(logic [STAT_W-1:0] status, logic [PRIO_W-1:0] prio,
                              logic [WORD_W-1:0] word, logic [OCC_W-1:0] occ);
      queue_reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got status %0h prio %0h word %0h occ %0h",
                 $time, status, prio, word, occ);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      report_field("status", e.status, status);
      report_field("head_priority", e.prio, prio);
      report_field("head_payload", e.word, word);
      report_field("occupancy", e.occ, occ);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [PRIO_W-1:0] in_new_priority;
  logic [WORD_W-1:0] in_new_payload;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [PRIO_W-1:0] out_head_priority;
  logic [WORD_W-1:0] out_head_payload;
  logic [OCC_W-1:0]  out_occupancy;

  priority_order_tracker tracker = new();

  // idle modes, set per phase by the stimulus
  bit tx_quiet;
  bit rx_quiet;
  int rx_hold;
  int quiet_cycles;
  int random_sent;

  sorted_priority_queue #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_new_priority   (in_new_priority),
    .in_new_payload    (in_new_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_head_priority (out_head_priority),
    .out_head_payload  (out_head_payload),
    .out_occupancy     (out_occupancy)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stall bursts, none started while rx_quiet is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
      if (!rx_quiet && $urandom_range(0, 3) == 0) rx_hold = idle_len();
    end
  end

  // monitor: both handshakes sampled at the edge, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_request(in_op, in_new_priority, in_new_payload);
      if (out_valid && !out_stall)
        tracker.check_reply(out_status, out_head_priority, out_head_payload, out_occupancy);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // offer one input word and hold it until taken, then maybe go idle
  task automatic push_word(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [WORD_W-1:0] word);
    int gap;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_new_priority <= prio;
    in_new_payload  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 2) == 0) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every owed reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  // random priority: mostly legal, sometimes 0 or 6..7 to hit the clamp
  function automatic logic [PRIO_W-1:0] pick_prio();
    if ($urandom_range(0, 9) == 0) return PRIO_W'($urandom_range(0, 7));
    return PRIO_W'($urandom_range(PRIO_MIN, PRIO_MAX));
  endfunction

  // random payload with the all-zero and all-one words mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    int enq_pct;
    int phase_len;
    int phase_idx;
    int k;
    logic [PRIO_W-1:0] dir_prio [10];

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_ENQ;
    in_new_priority = '0;
    in_new_payload  = '0;
    out_stall       = 1'b0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    rx_hold         = 0;
    quiet_cycles    = 0;
    random_sent     = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dequeue from empty first
    push_word(OP_DEQ, '0, '0);
    // fill to the top: clamp cases, ties, every legal priority, payload extremes
    dir_prio = '{3'd0, 3'd7, 3'd6, 3'd5, 3'd3, 3'd3, 3'd2, 3'd1, 3'd4, 3'd1};
    for (k = 0; k < DEPTH; k++) begin
      push_word(OP_ENQ, dir_prio[k % 10],
                (k == 0) ? '0 : ((k == 1) ? '1 : WORD_W'(32'hA5A5_0000 + k)));
    end
    // enqueue into a full queue
    push_word(OP_ENQ, PRIO_MAX, 32'h5A5A_5A5A);
    // drain everything, then dequeue from empty again
    for (k = 0; k < DEPTH; k++) push_word(OP_DEQ, PRIO_W'($urandom), $urandom);
    push_word(OP_DEQ, PRIO_W'($urandom), $urandom);

    // random phases that push toward full, toward empty, or hover
    phase_idx = 0;
    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        2:       enq_pct = 50;
        3:       enq_pct = 95;
        default: enq_pct = 5;
      endcase
      phase_len = $urandom_range(15, 60);
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < enq_pct) push_word(OP_ENQ, pick_prio(), pick_word());
        else push_word(OP_DEQ, PRIO_W'($urandom), $urandom);
        random_sent++;
      end
      // now and then let the whole pipeline empty out before going on
      if (phase_idx % 6 == 2) wait_drained();
      phase_idx++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending_replies.size() != 0) begin
      $display("%0t: %0d output words never arrived", $time, tracker.pending_replies.size());
      tracker.errors++;
    end

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
